[rtl/core/fwsd_pkg.sv]
package fwsd_pkg;

   localparam int MAX_WINDOW_DEF = 32;
   localparam int CHANNELS_DEF   = 2;
   localparam int NUM_CHAN       = 2;

   localparam int MIN_WINDOW = 8;
   localparam int MARK_LEN   = 4;

   localparam logic [7:0] HEAD_BYTE = 8'hFF;
   localparam logic [7:0] TAIL_BYTE = 8'hFE;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] LEN_A_RESET = 6'd24;
   localparam logic [LEN_W-1:0] LEN_B_RESET = 6'd26;
   localparam logic [NUM_CHAN-1:0] ENABLE_RESET = 2'b01;
   localparam logic [NUM_CHAN-1:0] STOP_RESET   = 2'b10;

   typedef enum logic [2:0] {
      REG_WINDOW_LEN_A    = 3'd0,
      REG_WINDOW_LEN_B    = 3'd1,
      REG_ENABLE_A        = 3'd2,
      REG_ENABLE_B        = 3'd3,
      REG_STOP_ON_MATCH_A = 3'd4,
      REG_STOP_ON_MATCH_B = 3'd5
   } reg_index_type;

endpackage

[rtl/core/fwsd_req_if.sv]
interface fwsd_req_if;
   logic                        valid;
   logic                        ready;
   logic [fwsd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/fwsd_rsp_if.sv]
interface fwsd_rsp_if;
   logic valid;
   logic ready;
   logic match_a;
   logic match_b;
   logic active_a;
   logic active_b;

   modport source (output valid, output match_a, output match_b,
                   output active_a, output active_b, input ready);
   modport sink   (input valid, input match_a, input match_b,
                   input active_a, input active_b, output ready);
endinterface

[rtl/core/frame_window_sync_detector.sv]
// Frame window sync detector.
// req_chan carries one received byte per request. Each of the two channels
// shifts the byte into its window of the last N bytes when active and flags
// a match when the four oldest bytes are 0xFF and the four newest are 0xFE.
// rsp_chan returns exactly one result per request: match and active flags
// of both channels after that byte.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle; the window update and match check take
// a single pass from the window registers into the result register.
// Out of reset, req_chan.ready is high when the result register is empty or
// being taken, so a stalled receiver holds the result and the next request
// waits. Reset (synchronous) empties the result register, clears all
// windows and loads the register defaults. Configure through the APB port
// while idle (unenforced); writing a length clears that channel's window.
module frame_window_sync_detector #(
   parameter int MAX_WINDOW = fwsd_pkg::MAX_WINDOW_DEF,
   parameter int CHANNELS   = fwsd_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   fwsd_req_if.sink                        req_chan,
   fwsd_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fwsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fwsd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fwsd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int NC     = fwsd_pkg::NUM_CHAN;
   localparam int ML     = fwsd_pkg::MARK_LEN;
   localparam int CLOG_W = $clog2(MAX_WINDOW + 1);
   localparam int EW     = (CLOG_W > fwsd_pkg::LEN_W) ? CLOG_W : fwsd_pkg::LEN_W;
   localparam logic [EW-1:0] MIN_LEN = EW'(fwsd_pkg::MIN_WINDOW);
   localparam logic [EW-1:0] MAX_LEN = EW'(MAX_WINDOW);

   logic [fwsd_pkg::LEN_W-1:0] len_ff   [NC];
   logic [fwsd_pkg::LEN_W-1:0] len_in   [NC];
   logic [NC-1:0]              on_ff, on_in;
   logic [NC-1:0]              stop_ff, stop_in;
   logic [NC-1:0]              hit;
   logic [NC-1:0]              len_wr;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [NC-1:0]              rsp_match_ff, rsp_match_in;
   logic [NC-1:0]              rsp_active_ff, rsp_active_in;

   logic                       req_accept;
   logic                       csr_write;
   fwsd_pkg::reg_index_type    csr_index;
   logic                       byte_head;
   logic                       byte_tail;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = fwsd_pkg::reg_index_type'(csr_paddr[fwsd_pkg::CSR_ADDR_W-1:2]);

   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign byte_head      = (req_chan.rx_byte == fwsd_pkg::HEAD_BYTE);
   assign byte_tail      = (req_chan.rx_byte == fwsd_pkg::TAIL_BYTE);

   assign len_wr[0] = csr_write && (csr_index == fwsd_pkg::REG_WINDOW_LEN_A);
   assign len_wr[1] = csr_write && (csr_index == fwsd_pkg::REG_WINDOW_LEN_B);

   for (genvar k = 0; k < NC; k++) begin : g_chan
      if (k < CHANNELS) begin : g_win
         logic [MAX_WINDOW-1:0] head_bits_ff, head_bits_in, head_shift;
         logic [ML-2:0]         tail_bits_ff, tail_bits_in, tail_shift;
         logic [EW-1:0]         len_ext, eff_len, tap_base;
         logic [MAX_WINDOW-1:0] head_taps;

         always_comb begin
            len_ext = EW'(len_ff[k]);
            if (len_ext < MIN_LEN) begin
               eff_len = MIN_LEN;
            end else if (len_ext > MAX_LEN) begin
               eff_len = MAX_LEN;
            end else begin
               eff_len = len_ext;
            end
            tap_base   = eff_len - EW'(ML);
            head_shift = {head_bits_ff[MAX_WINDOW-2:0], byte_head};
            tail_shift = {tail_bits_ff[ML-3:0], byte_tail};
            head_taps  = head_shift >> tap_base;

            head_bits_in = head_bits_ff;
            tail_bits_in = tail_bits_ff;
            if (len_wr[k]) begin
               head_bits_in = '0;
               tail_bits_in = '0;
            end else if (req_accept && on_ff[k]) begin
               head_bits_in = head_shift;
               tail_bits_in = tail_shift;
            end
         end

         assign hit[k] = on_ff[k] && byte_tail && (&tail_bits_ff) && (&head_taps[ML-1:0]);

         always_ff @(posedge clock) begin
            if (reset) begin
               head_bits_ff <= '0;
               tail_bits_ff <= '0;
            end else begin
               head_bits_ff <= head_bits_in;
               tail_bits_ff <= tail_bits_in;
            end
         end
      end else begin : g_none
         assign hit[k] = 1'b0;
      end
   end

   always_comb begin
      len_in  = len_ff;
      on_in   = on_ff;
      stop_in = stop_ff;
      if (req_accept) begin
         for (int k = 0; k < NC; k++) begin
            if (hit[k] && stop_ff[k]) begin
               on_in[k] = 1'b0;
            end
         end
      end
      if (csr_write) begin
         case (csr_index)
            fwsd_pkg::REG_WINDOW_LEN_A: begin
               len_in[0] = csr_pwdata[fwsd_pkg::LEN_W-1:0];
            end
            fwsd_pkg::REG_WINDOW_LEN_B: begin
               len_in[1] = csr_pwdata[fwsd_pkg::LEN_W-1:0];
            end
            fwsd_pkg::REG_ENABLE_A: begin
               on_in[0] = csr_pwdata[0];
            end
            fwsd_pkg::REG_ENABLE_B: begin
               on_in[1] = csr_pwdata[0];
            end
            fwsd_pkg::REG_STOP_ON_MATCH_A: begin
               stop_in[0] = csr_pwdata[0];
            end
            fwsd_pkg::REG_STOP_ON_MATCH_B: begin
               stop_in[1] = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         fwsd_pkg::REG_WINDOW_LEN_A:    csr_prdata = fwsd_pkg::CSR_DATA_W'(len_ff[0]);
         fwsd_pkg::REG_WINDOW_LEN_B:    csr_prdata = fwsd_pkg::CSR_DATA_W'(len_ff[1]);
         fwsd_pkg::REG_ENABLE_A:        csr_prdata = fwsd_pkg::CSR_DATA_W'(on_ff[0]);
         fwsd_pkg::REG_ENABLE_B:        csr_prdata = fwsd_pkg::CSR_DATA_W'(on_ff[1]);
         fwsd_pkg::REG_STOP_ON_MATCH_A: csr_prdata = fwsd_pkg::CSR_DATA_W'(stop_ff[0]);
         fwsd_pkg::REG_STOP_ON_MATCH_B: csr_prdata = fwsd_pkg::CSR_DATA_W'(stop_ff[1]);
         default:                       csr_prdata = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_active_in = rsp_active_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_match_in  = hit;
         rsp_active_in = on_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff[0]    <= fwsd_pkg::LEN_A_RESET;
         len_ff[1]    <= fwsd_pkg::LEN_B_RESET;
         on_ff        <= fwsd_pkg::ENABLE_RESET;
         stop_ff      <= fwsd_pkg::STOP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         on_ff        <= on_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_match_ff  <= rsp_match_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.match_a  = rsp_match_ff[0];
   assign rsp_chan.match_b  = rsp_match_ff[1];
   assign rsp_chan.active_a = rsp_active_ff[0];
   assign rsp_chan.active_b = rsp_active_ff[1];

endmodule

[rtl/core/fwsd_checker.sv]
module fwsd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_match_a,
   input logic rsp_match_b,
   input logic csr_pready
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_match_a)
                                        && $stable(rsp_match_b));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result dropped while stalled");

   property p_one_cycle;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready) |=> rsp_valid;
   endproperty
   a_one_cycle: assert property (p_one_cycle) else $error("result missing after request");

   property p_ready_when_empty;
      @(posedge clock) disable iff (reset)
         (!rsp_valid || rsp_ready) |-> req_ready;
   endproperty
   a_ready_when_empty: assert property (p_ready_when_empty)
      else $error("request stalled with free result slot");

   property p_reset_empty;
      @(posedge clock) $past(reset) |-> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("result valid after reset");

   property p_pready;
      @(posedge clock) disable iff (reset) csr_pready;
   endproperty
   a_pready: assert property (p_pready) else $error("pready low");

endmodule

bind frame_window_sync_detector fwsd_checker u_fwsd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_match_a (rsp_chan.match_a),
   .rsp_match_b (rsp_chan.match_b),
   .csr_pready  (csr_pready)
);
